[hdl/tpa_pkg.sv]
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared widths, command encodings and fixed-point helpers for the
// Toeplitz autocovariance block.
// ----------------------------------------------------------------------------
package tpa_pkg;

   localparam int DIM_DEFAULT  = 16;
   localparam int FRAC_DEFAULT = 16;
   localparam int DATA_W       = 32;
   localparam int PROD_W       = 64;
   localparam int DIM_REG_W    = 5;
   localparam int LAG_W        = 4;

   // multiplier operand pairs
   typedef enum logic [1:0] {
      MUL_KAP,
      MUL_CA,
      MUL_VAR
   } mul_sel_type;

   // coefficient row write source
   typedef enum logic {
      CW_KAPPA,
      CW_UPDATE
   } coeff_wsel_type;

   // autocorrelation write source
   typedef enum logic {
      AW_ONE,
      AW_ACC
   } ac_wsel_type;

   typedef struct packed {
      logic           load_var;
      logic           div_start;
      logic           div_step;
      logic           kappa_we;
      logic           kappa_re;
      logic           kap_load;
      logic           coeff_re;
      logic           coeff_we;
      coeff_wsel_type coeff_wsel;
      logic           ac_re;
      logic           ac_we;
      ac_wsel_type    ac_wsel;
      logic           mul_en;
      mul_sel_type    mul_sel;
      logic           acc_clr;
      logic           acc_en;
      logic           out_load;
      logic           out_last;
      logic           out_err;
   } cmd_type;

   typedef struct packed {
      logic in_zero;
   } status_type;

   // clamp to the signed 32-bit range
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'(64'sd2147483647);
      lo = -PROD_W'(64'sd2147483648);
      if (v > hi) begin
         return DATA_W'(hi);
      end else if (v < lo) begin
         return DATA_W'(lo);
      end else begin
         return DATA_W'(v);
      end
   endfunction

   // magnitude of a signed word, as unsigned
   function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
      if (v[DATA_W-1]) begin
         return DATA_W'(-v);
      end else begin
         return DATA_W'(v);
      end
   endfunction

endpackage

[hdl/tpa_datapath.sv]
// ----------------------------------------------------------------------------
// tpa_datapath
// Storage, bit-serial divider, shared multiplier, accumulator and result
// registers, all steered by the controller's commands.
// ----------------------------------------------------------------------------
module tpa_datapath import tpa_pkg::*; #(
   parameter int  MAX_DIM   = DIM_DEFAULT,
   parameter int  FRAC_BITS = FRAC_DEFAULT,
   localparam int IW        = $clog2(MAX_DIM)
) (
   input  logic                     clock,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic [DATA_W-1:0]        req_param_value,
   input  logic [IW-1:0]            kappa_addr,
   input  logic [IW:0]              coeff_addr,
   input  logic [IW-1:0]            ac_addr,
   output logic [LAG_W-1:0]         rsp_lag_num,
   output logic signed [DATA_W-1:0] rsp_scaled_autocov,
   output logic                     rsp_last_lag,
   output logic                     rsp_param_error
);

   localparam logic [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_BITS;
   localparam logic [PROD_W-1:0] HALF_Q = PROD_W'(1) << (FRAC_BITS - 1);

   logic [DATA_W-1:0]        var_ff;
   logic [DATA_W:0]          den_ff;
   logic [DATA_W+1:0]        rem_ff;
   logic [FRAC_BITS:0]       quo_ff;
   logic                     div_neg_ff;

   logic signed [DATA_W-1:0] kappa_mem [MAX_DIM];
   logic signed [DATA_W-1:0] coeff_mem [2*MAX_DIM];
   logic signed [DATA_W-1:0] ac_mem [MAX_DIM];
   logic signed [DATA_W-1:0] kappa_q_ff;
   logic signed [DATA_W-1:0] coeff_q_ff;
   logic signed [DATA_W-1:0] ac_q_ff;
   logic signed [DATA_W-1:0] kap_ff;

   logic [PROD_W-1:0]        prod_ff;
   logic                     prod_neg_ff;
   logic signed [PROD_W-1:0] acc_ff;

   logic                     p_lt;
   logic [DATA_W-1:0]        num;
   logic [DATA_W:0]          den;
   logic                     div_ge;
   logic [DATA_W+1:0]        div_diff;
   logic signed [DATA_W-1:0] kappa_wdata;
   logic [DATA_W-1:0]        mul_a;
   logic [DATA_W-1:0]        mul_b;
   logic                     mul_neg;
   logic [PROD_W-1:0]        rnd;
   logic signed [PROD_W-1:0] rq;
   logic signed [DATA_W-1:0] coeff_wdata;
   logic signed [DATA_W-1:0] ac_wdata;

   assign status.in_zero = (req_param_value == '0);

   // parameter to partial correlation: |p - 1| and p + 1
   assign p_lt = req_param_value < ONE_Q;
   assign num  = p_lt ? ONE_Q - req_param_value : req_param_value - ONE_Q;
   assign den  = {1'b0, req_param_value} + {1'b0, ONE_Q};

   // restoring division, one quotient bit per step
   assign div_ge   = rem_ff >= {1'b0, den_ff};
   assign div_diff = div_ge ? rem_ff - {1'b0, den_ff} : rem_ff;
   assign kappa_wdata = div_neg_ff ? DATA_W'(0) - DATA_W'(quo_ff) : DATA_W'(quo_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_var) begin
         var_ff <= req_param_value;
      end
      if (cmd.div_start) begin
         rem_ff     <= {2'b00, num};
         den_ff     <= den;
         div_neg_ff <= p_lt;
         quo_ff     <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= {div_diff[DATA_W:0], 1'b0};
         quo_ff <= {quo_ff[FRAC_BITS-1:0], div_ge};
      end
   end

   // kappa store
   always_ff @(posedge clock) begin
      if (cmd.kappa_we) begin
         kappa_mem[kappa_addr] <= kappa_wdata;
      end
      if (cmd.kappa_re) begin
         kappa_q_ff <= kappa_mem[kappa_addr];
      end
      if (cmd.kap_load) begin
         kap_ff <= kappa_q_ff;
      end
   end

   // multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         MUL_KAP: begin
            mul_a   = mag32(kap_ff);
            mul_b   = mag32(coeff_q_ff);
            mul_neg = kap_ff[DATA_W-1] ^ coeff_q_ff[DATA_W-1];
         end
         MUL_CA: begin
            mul_a   = mag32(coeff_q_ff);
            mul_b   = mag32(ac_q_ff);
            mul_neg = coeff_q_ff[DATA_W-1] ^ ac_q_ff[DATA_W-1];
         end
         MUL_VAR: begin
            mul_a   = var_ff;
            mul_b   = mag32(ac_q_ff);
            mul_neg = ac_q_ff[DATA_W-1];
         end
         default: begin
            mul_a   = '0;
            mul_b   = '0;
            mul_neg = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff     <= PROD_W'(mul_a) * PROD_W'(mul_b);
         prod_neg_ff <= mul_neg;
      end
   end

   // round to nearest, ties away from zero
   assign rnd = (prod_ff + HALF_Q) >> FRAC_BITS;
   assign rq  = prod_neg_ff ? -$signed(rnd) : $signed(rnd);

   // coefficient rows, two banks swapped each lag
   assign coeff_wdata = (cmd.coeff_wsel == CW_KAPPA) ? kappa_q_ff
                      : sat32(PROD_W'(coeff_q_ff) - rq);

   always_ff @(posedge clock) begin
      if (cmd.coeff_we) begin
         coeff_mem[coeff_addr] <= coeff_wdata;
      end
      if (cmd.coeff_re) begin
         coeff_q_ff <= coeff_mem[coeff_addr];
      end
   end

   // autocorrelation store
   assign ac_wdata = (cmd.ac_wsel == AW_ONE) ? $signed(ONE_Q) : sat32(acc_ff);

   always_ff @(posedge clock) begin
      if (cmd.ac_we) begin
         ac_mem[ac_addr] <= ac_wdata;
      end
      if (cmd.ac_re) begin
         ac_q_ff <= ac_mem[ac_addr];
      end
   end

   // accumulator
   always_ff @(posedge clock) begin
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_ff + rq;
      end
   end

   // result registers, lag taken from the autocorrelation address
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_lag_num        <= LAG_W'(ac_addr);
         rsp_scaled_autocov <= sat32(rq);
         rsp_last_lag       <= cmd.out_last;
         rsp_param_error    <= cmd.out_err;
      end
   end

endmodule

[hdl/tpa_ctrl.sv]
// ----------------------------------------------------------------------------
// tpa_ctrl
// Sequencer for item intake, the Durbin-Levinson recursion and result
// delivery; holds the dimension register and run bookkeeping.
// ----------------------------------------------------------------------------
module tpa_ctrl import tpa_pkg::*; #(
   parameter int  MAX_DIM   = DIM_DEFAULT,
   parameter int  FRAC_BITS = FRAC_DEFAULT,
   localparam int IW        = $clog2(MAX_DIM)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 csr_we,
   input  logic [DIM_REG_W-1:0] csr_wdata,
   input  status_type           status,
   output cmd_type              cmd,
   output logic [IW-1:0]        kappa_addr,
   output logic [IW:0]          coeff_addr,
   output logic [IW-1:0]        ac_addr
);

   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int CW = (DW > DIM_REG_W) ? DW : DIM_REG_W;
   localparam int SW = $clog2(FRAC_BITS + 2);

   typedef enum logic [4:0] {
      S_IDLE, S_DIV, S_KWR, S_RINIT, S_KRD, S_KLAT, S_URA, S_URB, S_UWR,
      S_ARD, S_AMUL, S_AACC, S_AWR, S_ORD, S_OMUL, S_OOUT, S_OWAIT
   } state_type;

   state_type            state_ff;
   logic [DIM_REG_W-1:0] dim_ff;
   logic [IW-1:0]        item_ff;
   logic [IW-1:0]        k_ff;
   logic [IW-1:0]        j_ff;
   logic [SW-1:0]        step_ff;
   logic                 bank_ff;
   logic                 err_ff;
   logic                 rsp_valid_ff;

   logic [CW-1:0]        dim_ext;
   logic [DW-1:0]        dim_eff;
   logic                 last_item;
   logic                 k_last;

   // effective dimension, clamped to 1 .. MAX_DIM
   always_comb begin
      dim_ext = CW'(dim_ff);
      if (dim_ext == '0) begin
         dim_eff = DW'(1);
      end else if (dim_ext > CW'(MAX_DIM)) begin
         dim_eff = DW'(MAX_DIM);
      end else begin
         dim_eff = DW'(dim_ext);
      end
   end

   assign last_item = (DW'(item_ff) + DW'(1)) >= dim_eff;
   assign k_last    = (DW'(k_ff) + DW'(1)) == dim_eff;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // state and bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dim_ff       <= DIM_REG_W'(1);
         item_ff      <= '0;
         k_ff         <= '0;
         j_ff         <= '0;
         step_ff      <= '0;
         bank_ff      <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            dim_ff  <= csr_wdata;
            item_ff <= '0;
            err_ff  <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (status.in_zero) begin
                     err_ff <= 1'b1;
                  end
                  if (item_ff == '0) begin
                     if (last_item) begin
                        state_ff <= S_RINIT;
                     end else begin
                        item_ff <= item_ff + IW'(1);
                     end
                  end else begin
                     step_ff  <= '0;
                     state_ff <= S_DIV;
                  end
               end
            end
            S_DIV: begin
               if (step_ff == SW'(FRAC_BITS)) begin
                  state_ff <= S_KWR;
               end else begin
                  step_ff <= step_ff + SW'(1);
               end
            end
            S_KWR: begin
               if (last_item) begin
                  item_ff  <= '0;
                  state_ff <= S_RINIT;
               end else begin
                  item_ff  <= item_ff + IW'(1);
                  state_ff <= S_IDLE;
               end
            end
            S_RINIT: begin
               if (dim_eff == DW'(1)) begin
                  k_ff     <= '0;
                  state_ff <= S_ORD;
               end else begin
                  k_ff     <= IW'(1);
                  state_ff <= S_KRD;
               end
            end
            S_KRD: begin
               state_ff <= S_KLAT;
            end
            S_KLAT: begin
               j_ff     <= IW'(1);
               state_ff <= (k_ff == IW'(1)) ? S_ARD : S_URA;
            end
            S_URA: begin
               state_ff <= S_URB;
            end
            S_URB: begin
               state_ff <= S_UWR;
            end
            S_UWR: begin
               if (j_ff + IW'(1) == k_ff) begin
                  j_ff     <= IW'(1);
                  state_ff <= S_ARD;
               end else begin
                  j_ff     <= j_ff + IW'(1);
                  state_ff <= S_URA;
               end
            end
            S_ARD: begin
               state_ff <= S_AMUL;
            end
            S_AMUL: begin
               state_ff <= S_AACC;
            end
            S_AACC: begin
               if (j_ff == k_ff) begin
                  state_ff <= S_AWR;
               end else begin
                  j_ff     <= j_ff + IW'(1);
                  state_ff <= S_ARD;
               end
            end
            S_AWR: begin
               bank_ff <= ~bank_ff;
               if (k_last) begin
                  k_ff     <= '0;
                  state_ff <= S_ORD;
               end else begin
                  k_ff     <= k_ff + IW'(1);
                  state_ff <= S_KRD;
               end
            end
            S_ORD: begin
               state_ff <= S_OMUL;
            end
            S_OMUL: begin
               state_ff <= S_OOUT;
            end
            S_OOUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_OWAIT;
            end
            S_OWAIT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (k_last) begin
                     err_ff   <= 1'b0;
                     state_ff <= S_IDLE;
                  end else begin
                     k_ff     <= k_ff + IW'(1);
                     state_ff <= S_ORD;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // datapath commands and addresses
   always_comb begin
      cmd        = '0;
      cmd.mul_sel = MUL_VAR;
      kappa_addr = '0;
      coeff_addr = '0;
      ac_addr    = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.load_var  = req_valid && (item_ff == '0);
            cmd.div_start = req_valid && (item_ff != '0);
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
         end
         S_KWR: begin
            cmd.kappa_we = 1'b1;
            kappa_addr   = item_ff - IW'(1);
         end
         S_RINIT: begin
            cmd.ac_we   = 1'b1;
            cmd.ac_wsel = AW_ONE;
         end
         S_KRD: begin
            cmd.kappa_re = 1'b1;
            kappa_addr   = k_ff - IW'(1);
         end
         S_KLAT: begin
            cmd.kap_load   = 1'b1;
            cmd.coeff_we   = 1'b1;
            cmd.coeff_wsel = CW_KAPPA;
            cmd.acc_clr    = 1'b1;
            coeff_addr     = {bank_ff, k_ff};
         end
         S_URA: begin
            cmd.coeff_re = 1'b1;
            coeff_addr   = {~bank_ff, k_ff - j_ff};
         end
         S_URB: begin
            cmd.coeff_re = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_KAP;
            coeff_addr   = {~bank_ff, j_ff};
         end
         S_UWR: begin
            cmd.coeff_we   = 1'b1;
            cmd.coeff_wsel = CW_UPDATE;
            coeff_addr     = {bank_ff, j_ff};
         end
         S_ARD: begin
            cmd.coeff_re = 1'b1;
            cmd.ac_re    = 1'b1;
            coeff_addr   = {bank_ff, j_ff};
            ac_addr      = k_ff - j_ff;
         end
         S_AMUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_CA;
         end
         S_AACC: begin
            cmd.acc_en = 1'b1;
         end
         S_AWR: begin
            cmd.ac_we   = 1'b1;
            cmd.ac_wsel = AW_ACC;
            ac_addr     = k_ff;
         end
         S_ORD: begin
            cmd.ac_re = 1'b1;
            ac_addr   = k_ff;
         end
         S_OMUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_VAR;
         end
         S_OOUT: begin
            cmd.out_load = 1'b1;
            cmd.out_last = k_last;
            cmd.out_err  = err_ff;
            ac_addr      = k_ff;
         end
         S_OWAIT: begin
            ac_addr = k_ff;
         end
         default: begin
            ac_addr = '0;
         end
      endcase
   end

endmodule

[hdl/toeplitz_pacf_autocovariance.sv]
// ----------------------------------------------------------------------------
// toeplitz_pacf_autocovariance
// Autocovariance first row from a variance and partial-correlation
// parameters, via the Durbin-Levinson recursion.
// ----------------------------------------------------------------------------
// A run is "dimension" requests: the variance, then dimension-1 parameters.
// The variance request is stored as is; each parameter (Q16.16 at default
// FRAC_BITS) goes through the bit-serial divider that maps p to (p-1)/(p+1).
// After the last request the recursion runs on one shared multiplier: lag k
// updates k-1 coefficients, then sums k products; each result waits on
// rsp_ready. No new request is taken until the run's last result is taken.
// A write to csr_wdata (dimension, 0 acts as 1, above MAX_DIM as MAX_DIM)
// abandons a partial run.
module toeplitz_pacf_autocovariance import tpa_pkg::*; #(
   parameter int MAX_DIM   = DIM_DEFAULT,
   parameter int FRAC_BITS = FRAC_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [DATA_W-1:0]        req_param_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [LAG_W-1:0]         rsp_lag_num,
   output logic signed [DATA_W-1:0] rsp_scaled_autocov,
   output logic                     rsp_last_lag,
   output logic                     rsp_param_error,
   input  logic                     csr_we,
   input  logic [DIM_REG_W-1:0]     csr_wdata
);

   localparam int IW = $clog2(MAX_DIM);

   cmd_type       cmd;
   status_type    status;
   logic [IW-1:0] kappa_addr;
   logic [IW:0]   coeff_addr;
   logic [IW-1:0] ac_addr;

   tpa_ctrl #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .status     (status),
      .cmd        (cmd),
      .kappa_addr (kappa_addr),
      .coeff_addr (coeff_addr),
      .ac_addr    (ac_addr)
   );

   tpa_datapath #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock              (clock),
      .cmd                (cmd),
      .status             (status),
      .req_param_value    (req_param_value),
      .kappa_addr         (kappa_addr),
      .coeff_addr         (coeff_addr),
      .ac_addr            (ac_addr),
      .rsp_lag_num        (rsp_lag_num),
      .rsp_scaled_autocov (rsp_scaled_autocov),
      .rsp_last_lag       (rsp_last_lag),
      .rsp_param_error    (rsp_param_error)
   );

   // intake and delivery never overlap
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result is pending");

   // the run's final result reopens intake
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_lag) |=> req_ready)
      else $error("intake not reopened after last lag");

   // an earlier lag keeps intake closed
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_lag) |=> !req_ready)
      else $error("intake reopened before last lag");

endmodule

[verif/tb_toeplitz_pacf_autocovariance.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_toeplitz_pacf_autocovariance
// Drives runs of variance and correlation parameters into the block under a
// range of dimension settings, predicts every autocovariance lag with an
// independent fixed-point Durbin-Levinson model and checks each response
// field by field, with bursty requests and random response stalls.
// ----------------------------------------------------------------------------
module tb_toeplitz_pacf_autocovariance;
   import tpa_pkg::*;

   localparam int MAXD      = 16;
   localparam int FRAC      = 16;
   localparam int IDLE_WAIT = 60;
   localparam int WDOG_MAX  = 6000;

   typedef struct {
      logic [LAG_W-1:0]  lag;
      logic [DATA_W-1:0] value;
      logic              last;
      logic              err;
   } lag_result_type;

   // ------------------------------------------------------------------------
   // autocovariance predictor and result store
   // ------------------------------------------------------------------------
   class autocov_scoreboard;
      logic [DIM_REG_W-1:0] dim_reg;
      longint unsigned      var_val;
      longint               kap[MAXD];
      longint               prow[MAXD];
      longint               crow[MAXD];
      longint               acorr[MAXD];
      int unsigned          run_pos;
      bit                   zero_seen;
      lag_result_type       pending_q[$];
      int                   errors;
      int                   requests;
      int                   results;
      int                   runs;

      function new();
         dim_reg   = 1;
         var_val   = 0;
         run_pos   = 0;
         zero_seen = 0;
         errors    = 0;
         requests  = 0;
         results   = 0;
         runs      = 0;
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint unsigned absval(longint v);
         return (v < 0) ? longint'(0) - v : v;
      endfunction

      // divide by 2^FRAC, nearest with ties away from zero
      function longint rnd_frac(bit neg, longint unsigned m);
         longint unsigned q;
         q = (m + (64'd1 << (FRAC - 1))) >> FRAC;
         return neg ? -longint'(q) : longint'(q);
      endfunction

      function longint fx_mul(longint a, longint b);
         return rnd_frac((a < 0) != (b < 0), absval(a) * absval(b));
      endfunction

      // partial correlation (p-1)/(p+1)
      function longint pacf_of(longint unsigned p);
         longint unsigned one;
         longint unsigned num;
         longint unsigned q;
         bit              neg;
         one = 64'd1 << FRAC;
         neg = p < one;
         num = neg ? one - p : p - one;
         q   = (num << FRAC) / (p + one);
         return neg ? -longint'(q) : longint'(q);
      endfunction

      function int unsigned used_dim();
         if (dim_reg < 1) return 1;
         if (dim_reg > MAXD) return MAXD;
         return dim_reg;
      endfunction

      function void write_dim(logic [DIM_REG_W-1:0] d);
         dim_reg   = d;
         run_pos   = 0;
         zero_seen = 0;
      endfunction

      function int pending();
         return pending_q.size();
      endfunction

      function void note_request(logic [DATA_W-1:0] p);
         int unsigned    d;
         int unsigned    idx;
         longint         acc;
         lag_result_type r;
         d   = used_dim();
         idx = (run_pos >= d) ? d - 1 : run_pos;
         requests++;
         if (p == 0) zero_seen = 1;
         if (idx == 0) var_val = p;
         else kap[idx-1] = pacf_of(p);
         if (idx + 1 < d) begin
            run_pos = idx + 1;
            return;
         end
         // levinson recursion over the stored partial correlations
         acorr[0] = longint'(1) << FRAC;
         for (int k = 1; k < d; k++) begin
            crow[k] = kap[k-1];
            for (int j = 1; j < k; j++)
               crow[j] = clamp32(prow[j] - fx_mul(kap[k-1], prow[k-j]));
            acc = 0;
            for (int j = 1; j <= k; j++)
               acc += fx_mul(crow[j], acorr[k-j]);
            acorr[k] = clamp32(acc);
            for (int j = 1; j <= k; j++)
               prow[j] = crow[j];
         end
         for (int k = 0; k < d; k++) begin
            r.lag   = LAG_W'(k);
            r.value = DATA_W'(clamp32(rnd_frac(acorr[k] < 0,
                                               var_val * absval(acorr[k]))));
            r.last  = (k + 1 == d);
            r.err   = zero_seen;
            pending_q = {pending_q, r};
         end
         runs++;
         run_pos   = 0;
         zero_seen = 0;
      endfunction

      task report(string what, longint got, longint exp_v);
         $display("mismatch %s: got %0h expected %0h", what, got, exp_v);
         errors++;
      endtask

      task check_result(logic [LAG_W-1:0] lag, logic [DATA_W-1:0] value,
                        logic last, logic err);
         lag_result_type e;
         results++;
         if (pending_q.size() == 0) begin
            report("unexpected response lag", lag, 0);
            return;
         end
         e = pending_q.pop_front();
         if (lag !== e.lag) report("lag number", lag, e.lag);
         if (value !== e.value) report("scaled_autocov", value, e.value);
         if (last !== e.last) report("last_lag", last, e.last);
         if (err !== e.err) report("param_error", err, e.err);
      endtask
   endclass

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_valid = 0;
   logic                     req_ready;
   logic [DATA_W-1:0]        req_param_value = 0;
   logic                     rsp_valid;
   logic                     rsp_ready = 0;
   logic [LAG_W-1:0]         rsp_lag_num;
   logic signed [DATA_W-1:0] rsp_scaled_autocov;
   logic                     rsp_last_lag;
   logic                     rsp_param_error;
   logic                     csr_we = 0;
   logic [DIM_REG_W-1:0]     csr_wdata = 0;

   autocov_scoreboard sb = new();
   int burst_left = 0;
   int stall_mode = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   int sent = 0;

   toeplitz_pacf_autocovariance uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_param_value(req_param_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_lag_num(rsp_lag_num),
      .rsp_scaled_autocov(rsp_scaled_autocov), .rsp_last_lag(rsp_last_lag),
      .rsp_param_error(rsp_param_error),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // response monitor, stall pattern and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_lag_num, rsp_scaled_autocov, rsp_last_lag, rsp_param_error);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || csr_we)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(4, 40);
         end
         stall_left--;
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (stall_left % 7) < 2;
         endcase
         if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("tb_toeplitz_pacf_autocovariance failed");
            $finish;
         end
      end
   end

   // one request, then sometimes a gap when the burst runs out
   task send_req(logic [DATA_W-1:0] p);
      int gap;
      req_valid       <= 1'b1;
      req_param_value <= p;
      do @(posedge clock); while (!req_ready);
      sb.note_request(p);
      sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // dimension write with the block drained and idle
   task set_dim(logic [DIM_REG_W-1:0] d);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= d;
      @(posedge clock);
      sb.write_dim(d);
      csr_we <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] rand_param();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 32'hFFFF_FFFF;
         2, 3: return $urandom;
         4: return $urandom_range(1, 32'h0000_4000);
         default: return $urandom_range(32'h0000_4000, 32'h0004_0000);
      endcase
   endfunction

   task send_run(int n);
      for (int i = 0; i < n; i++)
         send_req(i == 0 ? $urandom_range(32'h0000_8000, 32'h0100_0000) : rand_param());
   endtask

   initial begin
      int d;
      int waited;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset dimension of one, extremes of the variance
      send_req(32'h0000_0000);
      send_req(32'hFFFF_FFFF);
      send_req(32'h0001_0000);
      // zero acts as one
      set_dim(0);
      send_req(32'h0000_0001);
      // short run with zero, unit, max and tiny parameters
      set_dim(5);
      send_req(32'h0002_0000);
      send_req(32'h0000_0000);
      send_req(32'h0001_0000);
      send_req(32'hFFFF_FFFF);
      send_req(32'h0000_0001);
      // large variance with strong correlation saturates
      set_dim(2);
      send_req(32'hFFFF_FFFF);
      send_req(32'hFFFF_FFFF);
      // partial run abandoned by a write
      set_dim(4);
      send_req(32'h0003_0000);
      send_req(32'h0000_8000);
      set_dim(31);
      send_run(16);
      set_dim(16);
      send_run(16);

      // random phases, mostly small dimensions, a few at the top
      while (sent < 310) begin
         case ($urandom_range(0, 7))
            0: d = $urandom_range(16, 31);
            1: d = $urandom_range(0, 1);
            default: d = $urandom_range(2, 6);
         endcase
         set_dim(DIM_REG_W'(d));
         repeat ($urandom_range(1, 4)) begin
            if (d <= 1) send_run(1);
            else if (d > MAXD) send_run(MAXD);
            else send_run(d);
         end
         // occasional broken run left behind for the next write
         if (d > 2 && $urandom_range(0, 4) == 0) send_run($urandom_range(1, 2));
      end

      req_valid <= 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < WDOG_MAX * 4) begin
         @(posedge clock);
         waited++;
      end
      repeat (IDLE_WAIT) @(posedge clock);
      if (sb.pending() != 0) sb.report("responses still owed", sb.pending(), 0);
      $display("covered %0d requests in %0d runs, %0d responses checked",
               sb.requests, sb.runs, sb.results);
      $display("dimensions 0 to 31 incl. abandoned runs, zero and full-scale parameters");
      if (sb.errors == 0) begin
         $display("tb_toeplitz_pacf_autocovariance passed");
      end else begin
         $display("tb_toeplitz_pacf_autocovariance failed");
      end
      $finish;
   end

endmodule
